// ===== hdl/trtb_pkg.sv =====
`timescale 1ns / 1ps

package trtb_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_DURATION     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_LIMIT = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_YOYO         = CFG_IDX_W'(3);

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hdl/tween_repeat_timebase_top.sv =====
`timescale 1ns / 1ps

// tween time base: maps elapsed ticks to a position within the current pass
// channels: config writes (i_cfg_valid/o_cfg_ready, always ready) take an
//   index and data; input items (i_in_valid/o_in_ready) carry elapsed ticks
//   and force_reverse; result items (o_out_valid/i_out_ready) carry one
//   result per input item
// flow: with repeats enabled, an item runs through a bit-serial divider
//   giving one quotient bit per cycle, then steps through the post and
//   finish states, where its result is registered; the next item is taken
//   only after that, back in the idle state; with no repeats, or a zero
//   cycle length, the divider is skipped and the item goes straight to the
//   post and finish states
// one item is in work at a time; with repeats, the divider sets the rate
// reset: config registers clear to zero, the cycle count, direction and last
//   applied position clear, and no result is pending
// stall: a finished result sits in the output register; the next item may be
//   accepted and worked on, but it waits at its last step until the
//   receiver takes the pending result
module tween_repeat_timebase_top import trtb_pkg::*; #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [31:0]          i_elapsed_ticks,
    input  logic                 i_force_reverse,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_apply_value,
    output logic [31:0]          o_current_ticks,
    output logic [31:0]          o_total_ticks,
    output logic                 o_repeat_event,
    output logic                 o_finished
);

    localparam int EW = (TIME_WIDTH < 32) ? TIME_WIDTH : 32;
    localparam int CW = (TIME_WIDTH > 32) ? 33 : TIME_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_POST = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [EW-1:0]       r_dur;
    logic [EW-1:0]       r_delay;
    logic signed [15:0]  r_limit;
    logic                r_yoyo;

    logic [1:0]          r_state;
    logic [EW-1:0]       r_cycles;
    logic                r_back;
    logic [EW-1:0]       r_last;
    logic                r_last_valid;

    logic [EW-1:0]       r_t;
    logic                r_rev;
    logic [EW-1:0]       r_pt;
    logic                r_set;
    logic                r_fin;
    logic                r_ev;

    logic                r_out_valid;
    logic                r_apply;
    logic [31:0]         r_cur;
    logic [31:0]         r_tot;
    logic                r_rep;
    logic                r_done;

    logic [EW:0]         w_sum;
    logic [CW-1:0]       w_cyc;
    logic                w_in_acc;
    logic                w_no_div;
    logic                w_div_start;
    t_div_stat           w_div_stat;
    logic [EW-1:0]       w_quo;
    logic [CW-1:0]       w_rem;

    logic [EW-1:0]       w_times;
    logic                w_tvalid;
    logic [EW-1:0]       n_t;
    logic                n_set;
    logic                n_fin;
    logic                n_ev;
    logic [EW-1:0]       n_cycles;
    logic                n_back;

    logic                w_slot_free;
    logic [EW-1:0]       w_tout;
    logic                w_apply;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;

    // cycle length saturates at a time width of up to 32; wider keeps the carry
    assign w_sum = {1'b0, r_dur} + {1'b0, r_delay};
    assign w_cyc = (CW > EW) ? CW'(w_sum) :
                   (w_sum[EW] ? {CW{1'b1}} : CW'(w_sum[EW-1:0]));

    assign w_no_div    = (r_limit == 16'sd0) || (w_cyc == '0);
    assign w_div_start = w_in_acc && !w_no_div;

    trtb_div #(
        .NW (EW),
        .DW (CW)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_div_start),
        .i_dividend  (i_elapsed_ticks[EW-1:0]),
        .i_divisor   (w_cyc),
        .o_stat      (w_div_stat),
        .o_quotient  (w_quo),
        .o_remainder (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dur   <= '0;
            r_delay <= '0;
            r_limit <= '0;
            r_yoyo  <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_DURATION:     r_dur   <= i_cfg_data[EW-1:0];
                CFG_REPEAT_DELAY: r_delay <= i_cfg_data[EW-1:0];
                CFG_REPEAT_LIMIT: r_limit <= i_cfg_data[15:0];
                CFG_YOYO:         r_yoyo  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // cycle split: exact boundary belongs to the previous cycle
    always_comb begin
        w_tvalid = (w_rem != '0) || (w_quo != '0);
        w_times  = (w_rem == '0) ? w_quo - 1'b1 : w_quo;
        n_t      = r_t;
        n_set    = 1'b1;
        n_fin    = 1'b0;
        n_ev     = 1'b0;
        n_cycles = r_cycles;
        n_back   = r_back;
        if (r_limit == 16'sd0) begin
            if (r_t >= r_dur) begin
                n_fin = 1'b1;
                n_t   = r_dur;
            end
        end else if (w_cyc == '0) begin
            n_set = 1'b0;
            n_fin = 1'b1;
        end else if (w_rem > CW'(r_dur)) begin
            n_t = r_dur;
        end else begin
            n_t = (w_rem == '0) ? r_dur : w_rem[EW-1:0];
            if (w_tvalid && (w_times > r_cycles)) begin
                n_cycles = w_times;
                if (!r_limit[15] && (w_quo > EW'(r_limit[14:0]))) begin
                    n_fin = 1'b1;
                    n_set = 1'b0;
                end
                if (r_yoyo) begin
                    n_back = !r_back;
                end
                n_ev = 1'b1;
            end
        end
    end

    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_tout      = (r_set && (r_rev || r_back)) ? r_dur - r_pt : r_pt;
    assign w_apply     = r_set && (!r_last_valid || (w_tout != r_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cycles     <= '0;
            r_back       <= 1'b0;
            r_last       <= '0;
            r_last_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if ((r_state == ST_FIN) && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_in_acc) begin
                        r_state <= w_no_div ? ST_POST : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (w_div_stat.done) begin
                        r_state <= ST_POST;
                    end
                end
                ST_POST: begin
                    r_cycles <= n_cycles;
                    r_back   <= n_back;
                    r_state  <= ST_FIN;
                end
                ST_FIN: begin
                    if (w_slot_free) begin
                        if (w_apply) begin
                            r_last       <= w_tout;
                            r_last_valid <= 1'b1;
                        end
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_t   <= i_elapsed_ticks[EW-1:0];
            r_rev <= i_force_reverse;
        end
        if (r_state == ST_POST) begin
            r_pt  <= n_t;
            r_set <= n_set;
            r_fin <= n_fin;
            r_ev  <= n_ev;
        end
        if ((r_state == ST_FIN) && w_slot_free) begin
            r_apply <= w_apply;
            r_rep   <= r_ev;
            r_done  <= r_fin;
            if (!w_apply) begin
                r_cur <= '0;
                r_tot <= '0;
            end else if (r_dur == '0) begin
                r_cur <= 32'd1;
                r_tot <= 32'd1;
            end else begin
                r_cur <= 32'(w_tout);
                r_tot <= 32'(r_dur);
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_apply_value   = r_apply;
    assign o_current_ticks = r_cur;
    assign o_total_ticks   = r_tot;
    assign o_repeat_event  = r_rep;
    assign o_finished      = r_done;

    a_ready_not_dividing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_div_stat.busy)
        else $error("input ready while divider busy");

    a_done_to_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_stat.done |=> (r_state == ST_POST))
        else $error("divider result not taken");

    a_applied_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_apply_value) |->
            ((o_total_ticks != 32'd0) && (o_current_ticks <= o_total_ticks)))
        else $error("applied position out of range");

    a_idle_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_apply_value) |->
            ((o_current_ticks == 32'd0) && (o_total_ticks == 32'd0)))
        else $error("position reported without apply");

endmodule

// ===== hdl/trtb_div.sv =====
`timescale 1ns / 1ps

module trtb_div import trtb_pkg::*; #(
    parameter int NW = 32,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output t_div_stat     o_stat,
    output logic [NW-1:0] o_quotient,
    output logic [DW-1:0] o_remainder
);

    localparam int CNT_W = $clog2(NW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_div;

    logic [DW:0] w_trial;
    logic [DW:0] w_diff;
    logic        w_ge;

    // one quotient bit per cycle, restoring
    assign w_trial = {r_rem, r_quo[NW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign w_diff  = w_trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[NW-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DW-1:0] : w_trial[DW-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import trtb_pkg::*;

    localparam int PHASES        = 18;
    localparam int PHASE_ITEMS   = 100;
    localparam int SETTLE_CYCLES = 40;
    localparam int QUIET_LIMIT   = 2000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = '1;

    typedef struct packed {
        logic        apply;
        logic [31:0] cur;
        logic [31:0] tot;
        logic        rep;
        logic        fin;
    } t_tween_res;

    typedef struct {
        logic                 is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [31:0]          val;
        logic                 rev;
        logic                 typed;
        t_tween_res           want;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [31:0]          i_elapsed_ticks;
    logic                 i_force_reverse;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic                 o_apply_value;
    logic [31:0]          o_current_ticks;
    logic [31:0]          o_total_ticks;
    logic                 o_repeat_event;
    logic                 o_finished;

    tween_repeat_timebase_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_elapsed_ticks (i_elapsed_ticks),
        .i_force_reverse (i_force_reverse),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_apply_value   (o_apply_value),
        .o_current_ticks (o_current_ticks),
        .o_total_ticks   (o_total_ticks),
        .o_repeat_event  (o_repeat_event),
        .o_finished      (o_finished)
    );

    // model copy of the registers and the time base state
    logic [31:0]        cfg_dur;
    logic [31:0]        cfg_delay;
    logic signed [15:0] cfg_limit;
    logic               cfg_yoyo;
    logic [31:0]        cyc_count;
    logic               dir_back;
    logic [31:0]        last_pos;
    logic               last_ok;

    t_tween_res pending_q[$];
    t_dir_row   dir_tab[$];

    int  errors;
    int  n_items;
    int  n_results;
    int  n_applied;
    int  n_events;
    int  n_finished;
    int  n_settings;
    int  quiet;
    logic idle_off;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_tween_res advance_timebase(input logic [31:0] elapsed, input logic rev);
        logic [63:0] t;
        logic [63:0] dur;
        logic [63:0] cyc;
        logic [63:0] times;
        logic [63:0] ctimes;
        logic [63:0] rem;
        logic        fin;
        logic        set_val;
        logic        rep;
        logic        valid_times;
        t_tween_res  r;
        t = 64'(elapsed);
        dur = 64'(cfg_dur);
        fin = 1'b0;
        set_val = 1'b1;
        rep = 1'b0;
        r = '0;
        if (cfg_limit == 16'sd0) begin
            if (t >= dur) begin
                fin = 1'b1;
                t = dur;
            end
        end else begin
            cyc = dur + 64'(cfg_delay);
            if (cyc > 64'hFFFF_FFFF) cyc = 64'hFFFF_FFFF;
            if (cyc != 0) begin
                times = t / cyc;
                ctimes = times;
                rem = t - times * cyc;
                if (rem > dur) begin
                    t = dur;
                end else begin
                    valid_times = 1'b1;
                    if (rem == 0) begin
                        if (times == 0) valid_times = 1'b0;
                        else times = times - 1;
                        t = dur;
                    end else begin
                        t = rem;
                    end
                    if (valid_times && times > 64'(cyc_count)) begin
                        cyc_count = (times > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : times[31:0];
                        if (cfg_limit > 16'sd0 && ctimes > 64'(cfg_limit)) begin
                            fin = 1'b1;
                            set_val = 1'b0;
                        end
                        if (cfg_yoyo) dir_back = !dir_back;
                        rep = 1'b1;
                    end
                end
            end else begin
                set_val = 1'b0;
                fin = 1'b1;
            end
        end
        if (set_val && (rev || dir_back)) t = (dur - t) & 64'hFFFF_FFFF;
        if (set_val && (!last_ok || t[31:0] != last_pos)) begin
            last_pos = t[31:0];
            last_ok = 1'b1;
            r.apply = 1'b1;
            r.cur = (cfg_dur == 0) ? 32'd1 : t[31:0];
            r.tot = (cfg_dur == 0) ? 32'd1 : cfg_dur;
        end
        r.rep = rep;
        r.fin = fin;
        return r;
    endfunction

    function automatic t_dir_row row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        t_dir_row d;
        d = '{1'b1, idx, val, 1'b0, 1'b0, '0};
        return d;
    endfunction

    function automatic t_dir_row row_item(input logic [31:0] t, input logic rev);
        t_dir_row d;
        d = '{1'b0, '0, t, rev, 1'b0, '0};
        return d;
    endfunction

    function automatic t_dir_row row_typed(input logic [31:0] t, input logic rev,
                                           input t_tween_res want);
        t_dir_row d;
        d = '{1'b0, '0, t, rev, 1'b1, want};
        return d;
    endfunction

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_DURATION:     cfg_dur = val;
            CFG_REPEAT_DELAY: cfg_delay = val;
            CFG_REPEAT_LIMIT: cfg_limit = val[15:0];
            CFG_YOYO:         cfg_yoyo = val[0];
            default: ;
        endcase
    endtask

    task automatic send_item(input logic [31:0] t, input logic rev, input logic typed,
                             input t_tween_res want);
        int         gap;
        t_tween_res pred;
        gap = idle_off ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_elapsed_ticks <= t;
        i_force_reverse <= rev;
        do @(posedge i_clk); while (!o_in_ready);
        pred = advance_timebase(t, rev);
        pending_q.push_back(typed ? want : pred);
        n_items++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, name, want, got);
        end
    endtask

    // result side
    initial begin
        int         stall;
        t_tween_res want;
        repeat (3) @(posedge i_clk);
        forever begin
            stall = idle_off ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
            n_results++;
            if (o_apply_value === 1'b1) n_applied++;
            if (o_repeat_event === 1'b1) n_events++;
            if (o_finished === 1'b1) n_finished++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result item with no input item waiting", $time);
            end else begin
                want = pending_q.pop_front();
                cmp_field("apply_value", 32'(want.apply), 32'(o_apply_value));
                cmp_field("current_ticks", want.cur, o_current_ticks);
                cmp_field("total_ticks", want.tot, o_total_ticks);
                cmp_field("repeat_event", 32'(want.rep), 32'(o_repeat_event));
                cmp_field("finished", 32'(want.fin), 32'(o_finished));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet = quiet + 1;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0]        t;
        logic               rev;
        logic [31:0]        dur;
        logic [31:0]        delay;
        logic [15:0]        lim;
        logic [31:0]        lim_data;
        logic [31:0]        span32;
        logic [31:0]        back;
        logic [63:0]        period;
        logic [63:0]        tcur;
        logic               allow_wide;
        int                 sel;
        int                 pick;
        int                 pause_at;

        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_elapsed_ticks = '0;
        i_force_reverse = 1'b0;
        i_out_ready = 1'b0;
        idle_off = 1'b0;
        errors = 0;
        n_items = 0;
        n_results = 0;
        n_applied = 0;
        n_events = 0;
        n_finished = 0;
        n_settings = 1;
        quiet = 0;
        cfg_dur = '0;
        cfg_delay = '0;
        cfg_limit = '0;
        cfg_yoyo = 1'b0;
        cyc_count = '0;
        dir_back = 1'b0;
        last_pos = '0;
        last_ok = 1'b0;

        // after reset: zero duration, no repeat
        dir_tab.push_back(row_typed(32'd0, 1'b0, '{1'b1, 32'd1, 32'd1, 1'b0, 1'b1}));
        dir_tab.push_back(row_typed(32'hFFFF_FFFF, 1'b1, '{1'b0, 32'd0, 32'd0, 1'b0, 1'b1}));
        dir_tab.push_back(row_cfg(CFG_UNUSED, 32'hFFFF_FFFF));
        dir_tab.push_back(row_cfg(CFG_DURATION, 32'd100));
        dir_tab.push_back(row_typed(32'd40, 1'b0, '{1'b1, 32'd40, 32'd100, 1'b0, 1'b0}));
        dir_tab.push_back(row_item(32'd40, 1'b1));
        dir_tab.push_back(row_typed(32'd100, 1'b0, '{1'b1, 32'd100, 32'd100, 1'b0, 1'b1}));
        dir_tab.push_back(row_item(32'hFFFF_FFFF, 1'b1));
        dir_tab.push_back(row_cfg(CFG_DURATION, 32'hFFFF_FFFF));
        dir_tab.push_back(row_typed(32'hFFFF_FFFF, 1'b0,
                                    '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1}));
        dir_tab.push_back(row_typed(32'd0, 1'b0, '{1'b1, 32'd0, 32'hFFFF_FFFF, 1'b0, 1'b0}));
        // repeats with delay and yoyo, cycle of 15
        dir_tab.push_back(row_cfg(CFG_DURATION, 32'd10));
        dir_tab.push_back(row_cfg(CFG_REPEAT_DELAY, 32'd5));
        dir_tab.push_back(row_cfg(CFG_REPEAT_LIMIT, 32'd2));
        dir_tab.push_back(row_cfg(CFG_YOYO, 32'hFFFF_FFFF));
        dir_tab.push_back(row_item(32'd0, 1'b0));
        dir_tab.push_back(row_item(32'd15, 1'b0));
        dir_tab.push_back(row_item(32'd17, 1'b0));
        dir_tab.push_back(row_item(32'd27, 1'b0));
        dir_tab.push_back(row_item(32'd32, 1'b1));
        dir_tab.push_back(row_item(32'd47, 1'b0));
        dir_tab.push_back(row_item(32'd5, 1'b0));
        // zero cycle length, repeat forever
        dir_tab.push_back(row_cfg(CFG_DURATION, 32'd0));
        dir_tab.push_back(row_cfg(CFG_REPEAT_DELAY, 32'd0));
        dir_tab.push_back(row_cfg(CFG_REPEAT_LIMIT, 32'h0000_FFFF));
        dir_tab.push_back(row_typed(32'd7, 1'b0, '{1'b0, 32'd0, 32'd0, 1'b0, 1'b1}));
        dir_tab.push_back(row_cfg(CFG_DURATION, 32'd3));
        dir_tab.push_back(row_item(32'd4, 1'b0));
        dir_tab.push_back(row_item(32'hFFFF_FFFF, 1'b0));
        dir_tab.push_back(row_item(32'd13, 1'b1));
        // saturating cycle length, largest repeat count
        dir_tab.push_back(row_cfg(CFG_DURATION, 32'hFFFF_FFF0));
        dir_tab.push_back(row_cfg(CFG_REPEAT_DELAY, 32'hFFFF_FFFF));
        dir_tab.push_back(row_cfg(CFG_REPEAT_LIMIT, 32'h0000_7FFF));
        dir_tab.push_back(row_cfg(CFG_YOYO, 32'd0));
        dir_tab.push_back(row_item(32'hFFFF_FFFF, 1'b1));
        dir_tab.push_back(row_item(32'hFFFF_FFF5, 1'b0));
        // upper data bits of the limit are ignored
        dir_tab.push_back(row_cfg(CFG_REPEAT_LIMIT, 32'hABCD_0000));
        dir_tab.push_back(row_item(32'd3, 1'b1));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[k]) begin
            if (dir_tab[k].is_cfg) begin
                write_reg(dir_tab[k].idx, dir_tab[k].val);
            end else begin
                send_item(dir_tab[k].val, dir_tab[k].rev, dir_tab[k].typed, dir_tab[k].want);
            end
        end

        for (int ph = 0; ph < PHASES; ph++) begin
            sel = $urandom_range(0, 9);
            dur = (sel == 0) ? 32'd0 : (sel < 7) ? $urandom_range(1, 50) :
                  (sel < 9) ? $urandom_range(51, 5000) : $urandom;
            sel = $urandom_range(0, 9);
            delay = (sel < 4) ? 32'd0 : (sel < 8) ? $urandom_range(1, 50) :
                    (sel < 9) ? $urandom_range(51, 5000) : $urandom;
            sel = $urandom_range(0, 9);
            lim = 16'((sel < 3) ? 32'd0 : (sel < 5) ? 32'h0000_FFFF :
                      (sel < 8) ? $urandom_range(1, 6) :
                      (sel < 9) ? 32'h0000_7FFF : $urandom_range(0, 16'hFFFF));
            if (ph == PHASES - 2) begin
                dur = 32'hFFFF_FFFF;
                delay = 32'hFFFF_FFFF;
                lim = 16'h7FFF;
            end else if (ph == PHASES - 1) begin
                dur = $urandom_range(32'h1000_0000, 32'hFFFF_FFFE);
                delay = $urandom;
                lim = 16'hFFFF;
            end
            lim_data = $urandom;
            lim_data[15:0] = lim;
            write_reg(CFG_DURATION, dur);
            write_reg(CFG_REPEAT_DELAY, delay);
            write_reg(CFG_REPEAT_LIMIT, lim_data);
            write_reg(CFG_YOYO, $urandom);
            n_settings++;

            if (cfg_limit == 16'sd0) begin
                period = 64'(cfg_dur);
            end else begin
                period = 64'(cfg_dur) + 64'(cfg_delay);
                if (period > 64'hFFFF_FFFF) period = 64'hFFFF_FFFF;
            end
            span32 = (period == 0) ? 32'd16 : period[31:0];
            if (cfg_limit == 16'sd0) span32 = span32 / 8 + 1;
            allow_wide = (cfg_limit == 16'sd0) || (period >= 64'h10_0000);
            // start near the cycle count already reached so new cycles still raise events
            tcur = (cfg_limit != 16'sd0) ? 64'(cyc_count) * period : 64'd0;
            if (tcur > 64'hFFFF_FFFF) tcur = 64'd0;
            idle_off = ($urandom_range(0, 3) == 0);
            pause_at = $urandom_range(10, PHASE_ITEMS - 10);

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                rev = ($urandom_range(0, 7) == 0);
                if (pick < 68) tcur = tcur + 64'($urandom_range(0, span32));
                else if (pick < 78 && period != 0) tcur = (tcur / period + 1) * period;
                if (tcur > 64'hFFFF_FFFF) tcur = 64'hFFFF_FFFF;
                t = tcur[31:0];
                if (pick >= 86 && pick < 94) begin
                    back = $urandom_range(0, span32);
                    t = (back > t) ? 32'd0 : t - back;
                end else if (pick >= 94) begin
                    t = allow_wide ? $urandom : 32'd0;
                end
                send_item(t, rev, 1'b0, '0);
                if (n == pause_at) drain_results();
            end
        end

        idle_off = 1'b0;
        drain_results();
        if (pending_q.size() != 0) begin
            errors += pending_q.size();
            $display("%0t: %0d expected results never arrived", $time, pending_q.size());
        end
        $display("run covered %0d input items and %0d result items over %0d register settings",
                 n_items, n_results, n_settings);
        $display("results held %0d applied positions, %0d repeat events and %0d finishes",
                 n_applied, n_events, n_finished);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/trtb_pkg.sv
hdl/trtb_div.sv
hdl/tween_repeat_timebase_top.sv
bench/tb_top.sv
